>>> rtl/vpc_pkg.sv
// ---------------------------------------------------------------------------
// vpc_pkg
// Shared types and constants for the two-axis PI controller.
// ---------------------------------------------------------------------------
`default_nettype none

package vpc_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int PX_W   = 41;
    localparam int LIM_W  = 31;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int CNT_W  = 6;

    localparam logic [1:0] ACT_STEP  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] CFG_PROP_GAIN    = 2'd0;
    localparam logic [1:0] CFG_INTEG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_INTEG_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_OUTPUT_LIMIT = 2'd3;

    typedef enum logic {
        MODE_SQRT,
        MODE_DIV
    } t_unit_mode;

    typedef struct packed {
        logic       start;
        t_unit_mode mode;
    } t_unit_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_PX,
        S_MUL_PY,
        S_MUL_KDT,
        S_MUL_IX,
        S_MUL_IY,
        S_INC_Y,
        S_LOAD_I,
        S_LOAD_O,
        S_CL_INIT,
        S_CL_SHIFT,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_SQRT_WAIT,
        S_MUL_NX,
        S_DIV_X_GO,
        S_DIV_X_WAIT,
        S_MUL_NY,
        S_DIV_Y_GO,
        S_DIV_Y_WAIT,
        S_CL_DONE,
        S_FINAL
    } t_state;

endpackage

`default_nettype wire

>>> rtl/vpc_mul.sv
// ---------------------------------------------------------------------------
// vpc_mul
// Shared signed 33x33 multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module vpc_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [vpc_pkg::MUL_W-1:0]     i_a,
    input  wire logic signed [vpc_pkg::MUL_W-1:0]     i_b,
    output logic signed [vpc_pkg::PROD_W-1:0]         o_prod
);
    import vpc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> rtl/vpc_iter.sv
// ---------------------------------------------------------------------------
// vpc_iter
// Iterative unit: floor square root (two bits per cycle) or
// restoring division with a 31-bit quotient (one bit per cycle).
// ---------------------------------------------------------------------------
`default_nettype none

module vpc_iter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire vpc_pkg::t_unit_req            i_req,
    input  wire logic [vpc_pkg::RAD_W-1:0]     i_opa,
    input  wire logic [vpc_pkg::ROOT_W-1:0]    i_div,
    output logic                               o_done,
    output logic [vpc_pkg::ROOT_W-1:0]         o_result
);
    import vpc_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    t_unit_mode         r_mode, n_mode;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [RAD_W-1:0]   r_rad, n_rad;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [ROOT_W-1:0]  r_dvs, n_dvs;

    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_dvs  = r_dvs;
        rem_sh = '0;
        trial  = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_mode = i_req.mode;
            n_root = '0;
            n_dvs  = i_div;
            if (i_req.mode == MODE_SQRT) begin
                n_cnt = CNT_W'(ROOT_W);
                n_rad = i_opa;
                n_rem = '0;
            end else begin
                n_cnt = CNT_W'(LIM_W);
                n_rad = {i_opa[LIM_W-1:0], {(RAD_W-LIM_W){1'b0}}};
                n_rem = REM_W'(i_opa[2*LIM_W-1:LIM_W]);
            end
        end else if (r_busy) begin
            if (r_mode == MODE_SQRT) begin
                rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
                trial  = {1'b0, r_root, 2'b01};
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            end else begin
                rem_sh = {r_rem[REM_W-2:0], r_rad[RAD_W-1]};
                trial  = REM_W'(r_dvs);
                n_rad  = {r_rad[RAD_W-2:0], 1'b0};
            end
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_mode <= n_mode;
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_dvs  <= n_dvs;
    end

    assign o_done   = r_done;
    assign o_result = r_root;

endmodule

`default_nettype wire

>>> rtl/vector_pi_controller_2axis_top.sv
// ---------------------------------------------------------------------------
// vector_pi_controller_2axis_top
// Two-axis PI controller with vector-length anti-windup on the integrators
// and on the output.
//
// Input channel (i_in_valid / o_in_stall) takes one word per action: step,
// load integrators or clear integrators. Output channel (o_out_valid /
// i_out_stall) returns one word per input word: both drives and both
// integrators. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write it only while no word is in flight, and
// the block does not enforce this. Load, clear and the unused action go
// straight to the output step. A step multiplies both errors by the
// proportional gain; with the integral term it also updates both
// integrators, then per length clamp (integrator, then output after a load
// step when its limit is set) shifts the vector into range, squares it and,
// when the vector is over its limit, takes a square root and two divisions
// in the shared iterative unit, then the output step.
// o_in_stall is high while a word is processed. A finished word sits in the
// output register; a new word is accepted meanwhile, but its result waits
// until the previous one has been taken. Reset clears the gains, limits
// and integrators.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_pi_controller_2axis_top #(
    parameter int INTEG_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_error_x,
    input  wire logic signed [15:0] i_error_y,
    input  wire logic [15:0]        i_time_step,
    input  wire logic signed [15:0] i_load_x,
    input  wire logic signed [15:0] i_load_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_drive_x,
    output logic signed [15:0]      o_drive_y,
    output logic signed [15:0]      o_integ_x_out,
    output logic signed [15:0]      o_integ_y_out
);
    import vpc_pkg::*;

    localparam int W  = INTEG_WIDTH;
    localparam int VW = ((W > PX_W) ? W : PX_W) + 1;

    function automatic logic signed [W-1:0] sat_w(input logic signed [VW-1:0] v);
        logic [VW-W:0] top;
        top = v[VW-1:W-1];
        if ((&top) || !(|top)) begin
            sat_w = v[W-1:0];
        end else begin
            sat_w = {v[VW-1], {(W-1){~v[VW-1]}}};
        end
    endfunction

    function automatic logic [15:0] to_q88(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        logic [VW-16:0]       top;
        t   = v >>> 16;
        top = t[VW-1:15];
        if ((&top) || !(|top)) begin
            to_q88 = t[15:0];
        end else begin
            to_q88 = {t[VW-1], {15{~t[VW-1]}}};
        end
    endfunction

    t_state r_state, n_state;

    logic [15:0]             r_kp, r_ki;
    logic [14:0]             r_ilim, r_olim;
    logic signed [15:0]      r_ex, r_ey;
    logic [15:0]             r_dt;
    logic                    r_step, n_step;
    logic signed [W-1:0]     r_ix, n_ix, r_iy, n_iy;
    logic signed [PX_W-1:0]  r_px, n_px, r_py, n_py;
    logic [31:0]             r_kdt, n_kdt;
    logic signed [VW-1:0]    r_vx, n_vx, r_vy, n_vy;
    logic [VW-1:0]           r_ax, n_ax, r_ay, n_ay;
    logic                    r_big, n_big;
    logic [LIM_W-1:0]        r_lim, n_lim;
    logic [2*LIM_W:0]        r_acc, n_acc;
    logic [ROOT_W-1:0]       r_len, n_len;
    logic                    r_phase, n_phase;
    logic [15:0]             r_dx, n_dx, r_dy, n_dy, r_ox, n_ox, r_oy, n_oy;
    logic                    r_out_valid, n_out_valid;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    t_unit_req                u_req;
    logic [RAD_W-1:0]         u_opa;
    logic                     u_done;
    logic [ROOT_W-1:0]        u_result;

    logic                     in_acc, out_acc, integ_en, exceed, final_go;
    logic signed [VW-1:0]     inc_x, inc_y, drv_x, drv_y, q_val;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign integ_en = (r_ki != 16'd0) && (r_ilim != 15'd0);
    assign exceed   = r_big || (r_acc > (2*LIM_W+1)'(prod[2*LIM_W-1:0]));
    assign final_go = !r_out_valid || !i_out_stall;
    assign inc_x    = VW'(signed'(prod[47:8]));
    assign inc_y    = inc_x;
    assign q_val    = VW'(signed'({1'b0, u_result[LIM_W-1:0]}));

    vpc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    vpc_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (u_req),
        .i_opa    (u_opa),
        .i_div    (r_len),
        .o_done   (u_done),
        .o_result (u_result)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_action == ACT_STEP) ? S_MUL_PX : S_FINAL;
                end
            end
            S_MUL_PX:     n_state = S_MUL_PY;
            S_MUL_PY:     n_state = S_MUL_KDT;
            S_MUL_KDT:    n_state = integ_en ? S_MUL_IX : S_FINAL;
            S_MUL_IX:     n_state = S_MUL_IY;
            S_MUL_IY:     n_state = S_INC_Y;
            S_INC_Y:      n_state = S_LOAD_I;
            S_LOAD_I:     n_state = S_CL_INIT;
            S_LOAD_O:     n_state = S_CL_INIT;
            S_CL_INIT:    n_state = S_CL_SHIFT;
            S_CL_SHIFT: begin
                if (!(|r_ax[VW-1:LIM_W]) && !(|r_ay[VW-1:LIM_W])) begin
                    n_state = S_SQ0;
                end
            end
            S_SQ0:        n_state = S_SQ1;
            S_SQ1:        n_state = S_SQ2;
            S_SQ2:        n_state = S_SQ3;
            S_SQ3:        n_state = exceed ? S_SQRT_WAIT : S_CL_DONE;
            S_SQRT_WAIT: begin
                if (u_done) begin
                    n_state = (u_result == '0) ? S_CL_DONE : S_MUL_NX;
                end
            end
            S_MUL_NX:     n_state = S_DIV_X_GO;
            S_DIV_X_GO:   n_state = S_DIV_X_WAIT;
            S_DIV_X_WAIT: if (u_done) n_state = S_MUL_NY;
            S_MUL_NY:     n_state = S_DIV_Y_GO;
            S_DIV_Y_GO:   n_state = S_DIV_Y_WAIT;
            S_DIV_Y_WAIT: if (u_done) n_state = S_CL_DONE;
            S_CL_DONE: begin
                n_state = (!r_phase && (r_olim != 15'd0)) ? S_LOAD_O : S_FINAL;
            end
            S_FINAL:      if (final_go) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        u_req     = '{start: 1'b0, mode: MODE_SQRT};
        u_opa     = {1'b0, r_acc};
        case (r_state)
            S_MUL_PX: begin
                mul_a = MUL_W'(r_ex);
                mul_b = MUL_W'({1'b0, r_kp});
            end
            S_MUL_PY: begin
                mul_a = MUL_W'(r_ey);
                mul_b = MUL_W'({1'b0, r_kp});
            end
            S_MUL_KDT: begin
                mul_a = MUL_W'({1'b0, r_ki});
                mul_b = MUL_W'({1'b0, r_dt});
            end
            S_MUL_IX: begin
                mul_a = MUL_W'(r_ex);
                mul_b = {1'b0, prod[31:0]};
            end
            S_MUL_IY: begin
                mul_a = MUL_W'(r_ey);
                mul_b = {1'b0, r_kdt};
            end
            S_SQ0: begin
                mul_a = {2'b00, r_ax[LIM_W-1:0]};
                mul_b = {2'b00, r_ax[LIM_W-1:0]};
            end
            S_SQ1: begin
                mul_a = {2'b00, r_ay[LIM_W-1:0]};
                mul_b = {2'b00, r_ay[LIM_W-1:0]};
            end
            S_SQ2: begin
                mul_a = {2'b00, r_lim};
                mul_b = {2'b00, r_lim};
            end
            S_SQ3: begin
                u_req = '{start: exceed, mode: MODE_SQRT};
            end
            S_MUL_NX: begin
                mul_a = {2'b00, r_ax[LIM_W-1:0]};
                mul_b = {2'b00, r_lim};
            end
            S_MUL_NY: begin
                mul_a = {2'b00, r_ay[LIM_W-1:0]};
                mul_b = {2'b00, r_lim};
            end
            S_DIV_X_GO, S_DIV_Y_GO: begin
                u_req = '{start: 1'b1, mode: MODE_DIV};
                u_opa = {2'b00, prod[2*LIM_W-1:0]};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_step      = r_step;
        n_ix        = r_ix;
        n_iy        = r_iy;
        n_px        = r_px;
        n_py        = r_py;
        n_kdt       = r_kdt;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_big       = r_big;
        n_lim       = r_lim;
        n_acc       = r_acc;
        n_len       = r_len;
        n_phase     = r_phase;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_out_valid = r_out_valid && !out_acc;
        drv_x       = VW'(r_px) + VW'(r_ix);
        drv_y       = VW'(r_py) + VW'(r_iy);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_step = (i_action == ACT_STEP);
                    if (i_action == ACT_LOAD) begin
                        n_ix = sat_w(VW'(signed'({i_load_x, 16'h0000})));
                        n_iy = sat_w(VW'(signed'({i_load_y, 16'h0000})));
                    end else if (i_action == ACT_CLEAR) begin
                        n_ix = '0;
                        n_iy = '0;
                    end
                end
            end
            S_MUL_PY:  n_px = {prod[MUL_W-1:0], 8'h00};
            S_MUL_KDT: n_py = {prod[MUL_W-1:0], 8'h00};
            S_MUL_IX:  n_kdt = prod[31:0];
            S_MUL_IY:  n_ix = sat_w(VW'(r_ix) + inc_x);
            S_INC_Y:   n_iy = sat_w(VW'(r_iy) + inc_y);
            S_LOAD_I: begin
                n_vx    = VW'(r_ix);
                n_vy    = VW'(r_iy);
                n_lim   = {r_ilim, 16'h0000};
                n_phase = 1'b0;
            end
            S_LOAD_O: begin
                n_vx    = VW'(r_ix) + VW'(r_px);
                n_vy    = VW'(r_iy) + VW'(r_py);
                n_lim   = {r_olim, 16'h0000};
                n_phase = 1'b1;
            end
            S_CL_INIT: begin
                n_ax  = r_vx[VW-1] ? VW'(-r_vx) : VW'(r_vx);
                n_ay  = r_vy[VW-1] ? VW'(-r_vy) : VW'(r_vy);
                n_big = (n_ax > VW'(r_lim)) || (n_ay > VW'(r_lim));
            end
            S_CL_SHIFT: begin
                if ((|r_ax[VW-1:LIM_W]) || (|r_ay[VW-1:LIM_W])) begin
                    n_ax = r_ax >> 1;
                    n_ay = r_ay >> 1;
                end
            end
            S_SQ1:  n_acc = (2*LIM_W+1)'(prod[2*LIM_W-1:0]);
            S_SQ2:  n_acc = r_acc + (2*LIM_W+1)'(prod[2*LIM_W-1:0]);
            S_SQRT_WAIT: if (u_done) n_len = u_result;
            S_DIV_X_WAIT: begin
                if (u_done) n_vx = r_vx[VW-1] ? -q_val : q_val;
            end
            S_DIV_Y_WAIT: begin
                if (u_done) n_vy = r_vy[VW-1] ? -q_val : q_val;
            end
            S_CL_DONE: begin
                if (!r_phase) begin
                    n_ix = r_vx[W-1:0];
                    n_iy = r_vy[W-1:0];
                end else begin
                    n_ix = sat_w(r_vx - VW'(r_px));
                    n_iy = sat_w(r_vy - VW'(r_py));
                end
            end
            S_FINAL: begin
                if (final_go) begin
                    n_out_valid = 1'b1;
                    if (!r_step) begin
                        n_dx = '0;
                        n_dy = '0;
                    end else if (integ_en) begin
                        n_dx = to_q88(drv_x);
                        n_dy = to_q88(drv_y);
                    end else begin
                        n_dx = to_q88(VW'(r_px));
                        n_dy = to_q88(VW'(r_py));
                    end
                    n_ox = to_q88(VW'(r_ix));
                    n_oy = to_q88(VW'(r_iy));
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kp        <= '0;
            r_ki        <= '0;
            r_ilim      <= '0;
            r_olim      <= '0;
            r_ix        <= '0;
            r_iy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ix        <= n_ix;
            r_iy        <= n_iy;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:    r_kp   <= i_cfg_data;
                    CFG_INTEG_GAIN:   r_ki   <= i_cfg_data;
                    CFG_INTEG_LIMIT:  r_ilim <= i_cfg_data[14:0];
                    CFG_OUTPUT_LIMIT: r_olim <= i_cfg_data[14:0];
                    default:          r_kp   <= r_kp;
                endcase
            end
        end
        if (in_acc) begin
            r_ex <= i_error_x;
            r_ey <= i_error_y;
            r_dt <= i_time_step;
        end
        r_step  <= n_step;
        r_px    <= n_px;
        r_py    <= n_py;
        r_kdt   <= n_kdt;
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_big   <= n_big;
        r_lim   <= n_lim;
        r_acc   <= n_acc;
        r_len   <= n_len;
        r_phase <= n_phase;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_drive_x     = r_dx;
    assign o_drive_y     = r_dy;
    assign o_integ_x_out = r_ox;
    assign o_integ_y_out = r_oy;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input accepted without going busy");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (r_state == S_SQRT_WAIT || r_state == S_DIV_X_WAIT ||
                    r_state == S_DIV_Y_WAIT))
        else $error("iterative unit finished outside a wait state");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_dx) && $stable(r_ox)))
        else $error("stalled result lost");

endmodule

`default_nettype wire

>>> test/vector_pi_controller_2axis_checker.sv
// ---------------------------------------------------------------------------
// vector_pi_controller_2axis_checker
// Watches the input, output and configuration ports of the two-axis PI
// controller, predicts each result word in fixed point and compares it.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_pi_controller_2axis_checker #(
    parameter int INTEG_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_error_x,
    input  wire logic signed [15:0] i_error_y,
    input  wire logic [15:0]        i_time_step,
    input  wire logic signed [15:0] i_load_x,
    input  wire logic signed [15:0] i_load_y,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [15:0] i_drive_x,
    input  wire logic signed [15:0] i_drive_y,
    input  wire logic signed [15:0] i_integ_x_out,
    input  wire logic signed [15:0] i_integ_y_out,
    output int                      o_fail_count,
    output int                      o_pending
);
    import vpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] drive_x;
        logic signed [15:0] drive_y;
        logic signed [15:0] integ_x;
        logic signed [15:0] integ_y;
    } t_ctrl_word;

    t_ctrl_word    expected_q[$];
    logic [15:0]   kp, ki;
    logic [14:0]   ilim, olim;
    longint        acc_x, acc_y;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic limit_length(inout longint x, inout longint y, input logic [63:0] lim);
        logic [63:0] ax, ay, m, xs, ys, len;
        int s;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        s = 0;
        if (m <= lim && ax * ax + ay * ay <= lim * lim) return;
        while ((m >> s) >= (64'd1 << 31)) s++;
        xs = ax >> s;
        ys = ay >> s;
        len = root_floor(xs * xs + ys * ys);
        if (len == 0) return;
        xs = xs * lim / len;
        ys = ys * lim / len;
        x = (x < 0) ? -longint'(xs) : longint'(xs);
        y = (y < 0) ? -longint'(ys) : longint'(ys);
    endtask

    function automatic logic [15:0] to_q88(longint v);
        return 16'(clip(floor_shift(v, 16), 16));
    endfunction

    task automatic predict_word(output t_ctrl_word w);
        longint ex, ey, px, py, kdt, sx, sy;
        w = '0;
        if (i_action == ACT_STEP) begin
            ex = i_error_x;
            ey = i_error_y;
            px = ex * longint'(kp) * 256;
            py = ey * longint'(kp) * 256;
            if (ki != 0 && ilim != 0) begin
                kdt = longint'(ki) * longint'(i_time_step);
                acc_x = clip(acc_x + floor_shift(ex * kdt, 8), INTEG_WIDTH);
                acc_y = clip(acc_y + floor_shift(ey * kdt, 8), INTEG_WIDTH);
                limit_length(acc_x, acc_y, 64'(ilim) << 16);
                if (olim != 0) begin
                    sx = acc_x + px;
                    sy = acc_y + py;
                    limit_length(sx, sy, 64'(olim) << 16);
                    acc_x = clip(sx - px, INTEG_WIDTH);
                    acc_y = clip(sy - py, INTEG_WIDTH);
                end
                w.drive_x = to_q88(px + acc_x);
                w.drive_y = to_q88(py + acc_y);
            end else begin
                w.drive_x = to_q88(px);
                w.drive_y = to_q88(py);
            end
        end else if (i_action == ACT_LOAD) begin
            acc_x = clip(longint'(i_load_x) * 65536, INTEG_WIDTH);
            acc_y = clip(longint'(i_load_y) * 65536, INTEG_WIDTH);
        end else if (i_action == ACT_CLEAR) begin
            acc_x = 0;
            acc_y = 0;
        end
        w.integ_x = to_q88(acc_x);
        w.integ_y = to_q88(acc_y);
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_ctrl_word w, got;
        if (!i_rst_n) begin
            kp <= '0; ki <= '0; ilim <= '0; olim <= '0;
            acc_x = 0;
            acc_y = 0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:    kp <= i_cfg_data;
                    CFG_INTEG_GAIN:   ki <= i_cfg_data;
                    CFG_INTEG_LIMIT:  ilim <= i_cfg_data[14:0];
                    CFG_OUTPUT_LIMIT: olim <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_word(w);
                expected_q.push_back(w);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_drive_x, i_drive_y, i_integ_x_out, i_integ_y_out};
                if (expected_q.size() == 0) begin
                    $error("unexpected result word");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = expected_q.pop_front();
                    if (got != w) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.drive_x != w.drive_x)
                            $error("drive_x exp %0d got %0d", w.drive_x, got.drive_x);
                        if (got.drive_y != w.drive_y)
                            $error("drive_y exp %0d got %0d", w.drive_y, got.drive_y);
                        if (got.integ_x != w.integ_x)
                            $error("integ_x_out exp %0d got %0d", w.integ_x, got.integ_x);
                        if (got.integ_y != w.integ_y)
                            $error("integ_y_out exp %0d got %0d", w.integ_y, got.integ_y);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> test/vector_pi_controller_2axis_top_tb.sv
// ---------------------------------------------------------------------------
// vector_pi_controller_2axis_top_tb
// Drives directed and random control words through several gain and limit
// settings with bursty input and stalling output; the checker judges results.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_pi_controller_2axis_top_tb;
    import vpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic               clk, rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [15:0]        cfg_data;
    logic               in_valid, in_stall;
    logic [1:0]         action;
    logic signed [15:0] error_x, error_y, load_x, load_y;
    logic [15:0]        time_step;
    logic               out_valid, out_stall;
    logic signed [15:0] drive_x, drive_y, integ_x_out, integ_y_out;
    int                 fail_count, pending;
    bit                 hold_out;

    vector_pi_controller_2axis_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_error_x(error_x), .i_error_y(error_y),
        .i_time_step(time_step), .i_load_x(load_x), .i_load_y(load_y),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_drive_x(drive_x), .o_drive_y(drive_y),
        .o_integ_x_out(integ_x_out), .o_integ_y_out(integ_y_out)
    );

    vector_pi_controller_2axis_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_action(action), .i_error_x(error_x), .i_error_y(error_y),
        .i_time_step(time_step), .i_load_x(load_x), .i_load_y(load_y),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_drive_x(drive_x), .i_drive_y(drive_y),
        .i_integ_x_out(integ_x_out), .i_integ_y_out(integ_y_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("[vector_pi_controller_2axis_top] ERROR");
        $finish;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int mode, n;
        out_stall = 0;
        @(posedge clk);
        forever begin
            if (hold_out) begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                hold_out = 0;
            end
            mode = $urandom_range(0, 3);
            n = $urandom_range(1, 40);
            repeat (n) begin
                out_stall <= (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 :
                             ($urandom_range(0, 2) == 0);
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_word(logic [1:0] act, logic [15:0] ex, logic [15:0] ey,
                             logic [15:0] dt, logic [15:0] lx, logic [15:0] ly);
        in_valid <= 1;
        action <= act;
        error_x <= ex; error_y <= ey; time_step <= dt;
        load_x <= lx; load_y <= ly;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_word();
        int r;
        logic [1:0] act;
        r = $urandom_range(0, 99);
        act = (r < 80) ? ACT_STEP : (r < 90) ? ACT_LOAD : (r < 97) ? ACT_CLEAR : ACT_UNUSED;
        send_word(act, pick_val(), pick_val(), pick_val(), pick_val(), pick_val());
    endtask

    task automatic set_regs(logic [15:0] kp, logic [15:0] ki, logic [15:0] il,
                            logic [15:0] ol);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_INTEG_LIMIT, il);
        write_reg(CFG_OUTPUT_LIMIT, ol);
        cfg_we <= 0;
    endtask

    initial begin
        int gap, burst;
        rst_n = 0;
        cfg_we = 0; cfg_idx = '0; cfg_data = '0;
        in_valid = 0; action = '0;
        error_x = '0; error_y = '0; time_step = '0; load_x = '0; load_y = '0;
        hold_out = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, then extremes with integral and clamps active
        send_word(ACT_STEP, 16'h7FFF, 16'h8000, 16'hFFFF, '0, '0);
        send_word(ACT_UNUSED, '0, '0, '0, '0, '0);
        in_valid <= 0;
        drain();
        set_regs(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000);
        send_word(ACT_LOAD, '0, '0, '0, 16'h7FFF, 16'h8000);
        send_word(ACT_STEP, 16'h7FFF, 16'h7FFF, 16'hFFFF, '0, '0);
        send_word(ACT_STEP, 16'h8000, 16'h8000, 16'hFFFF, '0, '0);
        send_word(ACT_STEP, 16'h0100, 16'hFF00, 16'h1000, '0, '0);
        send_word(ACT_CLEAR, '0, '0, '0, '0, '0);
        send_word(ACT_STEP, '0, '0, '0, '0, '0);
        in_valid <= 0;
        drain();
        set_regs(16'h0100, 16'h0200, 16'h0001, 16'h0001);
        send_word(ACT_STEP, 16'h0300, 16'hFC00, 16'h4000, '0, '0);
        send_word(ACT_LOAD, '0, '0, '0, 16'h8000, 16'h7FFF);
        send_word(ACT_STEP, 16'h8000, 16'h7FFF, 16'hFFFF, '0, '0);
        send_word(ACT_STEP, 16'h0001, 16'h0000, 16'h0001, '0, '0);
        in_valid <= 0;
        drain();
        set_regs(16'h0080, 16'h0000, 16'h7FFF, 16'h7FFF);
        send_word(ACT_STEP, 16'h1234, 16'hEDCB, 16'h0100, '0, '0);
        in_valid <= 0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_regs(16'h0100, 16'h0400, 16'h0800, 16'h1000);
                1: set_regs(16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000);
                2: set_regs(16'hFFFF, 16'h0001, 16'h0001, 16'h7FFF);
                default: set_regs(16'($urandom), 16'($urandom),
                                  16'($urandom_range(0, 32767)),
                                  16'($urandom_range(0, 32767)));
            endcase
            for (int k = 0; k < 255; ) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    if (phase == 2 && k == 100) hold_out = 1;
                    if (phase == 3 && k == 120) begin
                        in_valid <= 0;
                        do @(posedge clk); while (pending != 0);
                    end
                    random_word();
                    k++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                if (gap != 0) begin
                    in_valid <= 0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid <= 0;
            drain();
        end

        if (fail_count == 0) begin
            $display("[vector_pi_controller_2axis_top] OK");
        end else begin
            $display("[vector_pi_controller_2axis_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> vector_pi_controller_2axis_top.f
rtl/vpc_pkg.sv
rtl/vpc_mul.sv
rtl/vpc_iter.sv
rtl/vector_pi_controller_2axis_top.sv
test/vector_pi_controller_2axis_checker.sv
test/vector_pi_controller_2axis_top_tb.sv
